FILE: sv/record_table_search_delete_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the record table
// Implication checks on a single clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef RECORD_TABLE_SEARCH_DELETE_TOP_ASSERT_SVH
`define RECORD_TABLE_SEARCH_DELETE_TOP_ASSERT_SVH

// same-cycle implication
`define RTS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("record table check failed");

// next-cycle implication
`define RTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("record table check failed");

`endif

FILE: sv/rts_pkg.sv
// ----------------------------------------------------------------------------
// rts_pkg
// Shared types and codes for the record table search/delete block.
// ----------------------------------------------------------------------------
package rts_pkg;

   localparam int TABLE_DEPTH_DEF = 128;
   localparam int KEY_W   = 32;
   localparam int SCORE_W = 10;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 8;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_MISS  = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [SCORE_W-1:0] a;
      logic [SCORE_W-1:0] b;
      logic [SCORE_W-1:0] c;
   } rec_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT,
      S_OUT
   } state_type;

endpackage

FILE: sv/rts_mem.sv
// ----------------------------------------------------------------------------
// rts_mem
// Record storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rts_mem #(
   parameter int TABLE_DEPTH = rts_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  rts_pkg::rec_type               wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output rts_pkg::rec_type               rd_data
);
   import rts_pkg::*;

   rec_type mem_ff [TABLE_DEPTH];
   rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/rts_ctrl.sv
// ----------------------------------------------------------------------------
// rts_ctrl
// Command sequencer: insert, linear search and shift-down delete over the
// record memory, plus the result register.
// ----------------------------------------------------------------------------
module rts_ctrl #(
   parameter int TABLE_DEPTH = rts_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rts_pkg::CMD_W-1:0]      req_cmd,
   input  logic [rts_pkg::KEY_W-1:0]      req_key,
   input  logic [rts_pkg::SCORE_W-1:0]    req_score_a,
   input  logic [rts_pkg::SCORE_W-1:0]    req_score_b,
   input  logic [rts_pkg::SCORE_W-1:0]    req_score_c,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rts_pkg::status_type            rsp_status,
   output rts_pkg::rec_type               rsp_rec,
   output logic [rts_pkg::COUNT_W-1:0]    rsp_count,
   output logic                           mem_wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0] mem_wr_addr,
   output rts_pkg::rec_type               mem_wr_data,
   output logic                           mem_rd_en,
   output logic [$clog2(TABLE_DEPTH)-1:0] mem_rd_addr,
   input  rts_pkg::rec_type               mem_rd_data
);
   import rts_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // zero every byte after the first zero byte
   function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] r;
      logic             live;
      r    = '0;
      live = 1'b1;
      for (int b = KEY_W/8 - 1; b >= 0; b--) begin
         if (k[8*b +: 8] == 8'h00) live = 1'b0;
         if (live) r[8*b +: 8] = k[8*b +: 8];
      end
      return r;
   endfunction

   // ASCII upper case to lower case, byte by byte
   function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] r;
      r = k;
      for (int b = 0; b < KEY_W/8; b++) begin
         if (k[8*b +: 8] >= 8'h41 && k[8*b +: 8] <= 8'h5A) begin
            r[8*b +: 8] = k[8*b +: 8] + 8'h20;
         end
      end
      return r;
   endfunction

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic               del_ff, del_in;
   status_type         res_status_ff, res_status_in;
   rec_type            res_rec_ff, res_rec_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   rec_type            rsp_rec_ff, rsp_rec_in;
   logic [CNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;

   logic               accept;
   logic [KEY_W-1:0]   req_key_trim;
   logic [CNT_W-1:0]   idx_p1;
   logic [CNT_W-1:0]   idx_p2;
   logic               hit;
   logic               full;
   logic [CNT_W+COUNT_W-1:0] cnt_ext;

   assign req_stall    = reset || (state_ff != S_IDLE);
   assign accept       = req_valid && !req_stall;
   assign req_key_trim = trim_key(req_key);
   assign idx_p1       = CNT_W'(idx_ff) + CNT_W'(1);
   assign idx_p2       = CNT_W'(idx_ff) + CNT_W'(2);
   assign hit          = (fold_key(mem_rd_data.key) == fold_key(key_ff));
   assign full         = (count_ff == CNT_W'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      key_ff        <= key_in;
      del_ff        <= del_in;
      res_status_ff <= res_status_in;
      res_rec_ff    <= res_rec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      del_in        = del_ff;
      res_status_in = res_status_ff;
      res_rec_in    = res_rec_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = idx_ff;
      mem_wr_data   = mem_rd_data;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in     = req_key_trim;
               del_in     = (req_cmd == CMD_DELETE);
               idx_in     = '0;
               res_rec_in = '0;
               state_in   = S_OUT;
               unique case (req_cmd) inside
                  CMD_INSERT: begin
                     if (req_key_trim == '0) begin
                        res_status_in = ST_EMPTY;
                     end else if (full) begin
                        res_status_in = ST_FULL;
                     end else begin
                        mem_wr_en     = 1'b1;
                        mem_wr_addr   = count_ff[IDX_W-1:0];
                        mem_wr_data   = '{key: req_key_trim, a: req_score_a,
                                          b: req_score_b, c: req_score_c};
                        count_in      = count_ff + CNT_W'(1);
                        res_status_in = ST_OK;
                     end
                  end
                  CMD_SEARCH, CMD_DELETE: begin
                     if (req_key_trim == '0) begin
                        res_status_in = ST_EMPTY;
                     end else if (count_ff == '0) begin
                        res_status_in = ST_MISS;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        state_in    = S_SEARCH;
                     end
                  end
                  default: begin
                     res_status_in = ST_MISS;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (hit) begin
               res_rec_in    = mem_rd_data;
               res_status_in = ST_OK;
               if (del_ff) begin
                  if (idx_p1 < count_ff) begin
                     // fetch the successor; idx_ff stays as the write slot
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = idx_p1[IDX_W-1:0];
                     state_in    = S_SHIFT;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                     state_in = S_OUT;
                  end
               end else begin
                  state_in = S_OUT;
               end
            end else if (idx_p1 < count_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_p1[IDX_W-1:0];
               idx_in      = idx_p1[IDX_W-1:0];
            end else begin
               res_status_in = ST_MISS;
               state_in      = S_OUT;
            end
         end
         S_SHIFT: begin
            // move entry idx+1 (read last cycle) down into idx
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_ff;
            mem_wr_data = mem_rd_data;
            if (idx_p2 < count_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_p2[IDX_W-1:0];
               idx_in      = idx_p1[IDX_W-1:0];
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_rec_in    = res_rec_ff;
               rsp_cnt_in    = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign cnt_ext    = {{COUNT_W{1'b0}}, rsp_cnt_ff};
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_rec    = rsp_rec_ff;
   assign rsp_count  = cnt_ext[COUNT_W-1:0];

endmodule

FILE: sv/record_table_search_delete_top.sv
// ----------------------------------------------------------------------------
// record_table_search_delete_top
// Unsorted record table with insert, case-insensitive search and delete.
// ----------------------------------------------------------------------------
// Operation: insert, empty key and unused command pass straight to the result
//   state; search reads entries in order up to a hit or the count; delete then
//   shifts each later entry down. Throughput: one item at a time, search/delete
//   paced by the single read port walking the record memory one entry per cycle.
// Reset: synchronous, clears the record count and handshake state; the
//   memory is not cleared since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module record_table_search_delete_top #(
   parameter int TABLE_DEPTH = rts_pkg::TABLE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rts_pkg::CMD_W-1:0]     req_cmd,
   input  logic [rts_pkg::KEY_W-1:0]     req_key,
   input  logic [rts_pkg::SCORE_W-1:0]   req_score_a,
   input  logic [rts_pkg::SCORE_W-1:0]   req_score_b,
   input  logic [rts_pkg::SCORE_W-1:0]   req_score_c,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rts_pkg::STAT_W-1:0]    rsp_status,
   output logic [rts_pkg::KEY_W-1:0]     rsp_found_key,
   output logic [rts_pkg::SCORE_W-1:0]   rsp_found_a,
   output logic [rts_pkg::SCORE_W-1:0]   rsp_found_b,
   output logic [rts_pkg::SCORE_W-1:0]   rsp_found_c,
   output logic [rts_pkg::COUNT_W-1:0]   rsp_count
);
   import rts_pkg::*;

`include "record_table_search_delete_top_assert.svh"

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   // count field is taken modulo 256
   localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(TABLE_DEPTH);

   // memory port wiring between sequencer and storage
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   rec_type          mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   rec_type          mem_rd_data;

   status_type       status;
   rec_type          rec;

   rts_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_key     (req_key),
      .req_score_a (req_score_a),
      .req_score_b (req_score_b),
      .req_score_c (req_score_c),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (status),
      .rsp_rec     (rec),
      .rsp_count   (rsp_count),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   rts_mem #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_status    = status;
   assign rsp_found_key = rec.key;
   assign rsp_found_a   = rec.a;
   assign rsp_found_b   = rec.b;
   assign rsp_found_c   = rec.c;

   // the request side is still busy in the cycle after an item is accepted
   `RTS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // table-full answer only when the count sits at the depth
   `RTS_ASSERT_NOW(a_full_count, clock, reset, rsp_valid && status == ST_FULL,
                   rsp_count == FULL_CNT)
   // no record is reported unless the operation found one
   `RTS_ASSERT_NOW(a_miss_no_record, clock, reset, rsp_valid && status != ST_OK,
                   rsp_found_key == '0 && rsp_found_a == '0)
   // the sequencer never writes and reads the same entry in one cycle
   `RTS_ASSERT_NOW(a_no_rw_clash, clock, reset, mem_wr_en && mem_rd_en,
                   mem_wr_addr != mem_rd_addr)

endmodule

FILE: tb/record_table_search_delete_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// record_table_search_delete_top_tb
// Drives insert, search and delete items into the record table and checks
// every result against a scoreboard model of the table held in the bench, or a typed row's result.
// ----------------------------------------------------------------------------
module record_table_search_delete_top_tb;
   import rts_pkg::*;

   localparam int          DEPTH       = TABLE_DEPTH_DEF;
   localparam int          RAND_ITEMS  = 1925;
   localparam int          CYCLE_LIMIT = 4_000_000;
   localparam int          DRAIN_WAIT  = 300;
   localparam logic [1:0]  CMD_UNUSED  = 2'd3;

   // one expected result item
   typedef struct {
      status_type         st;
      logic [KEY_W-1:0]   key;
      logic [SCORE_W-1:0] a;
      logic [SCORE_W-1:0] b;
      logic [SCORE_W-1:0] c;
      logic [COUNT_W-1:0] cnt;
   } outcome_type;

   // one row of the directed stimulus table
   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [KEY_W-1:0]   key;
      logic [SCORE_W-1:0] a;
      logic [SCORE_W-1:0] b;
      logic [SCORE_W-1:0] c;
      bit                 typed;
      outcome_type        want;
   } step_type;

   logic clock;
   logic reset = 1'b1;

   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   logic [CMD_W-1:0]     req_cmd     = '0;
   logic [KEY_W-1:0]     req_key     = '0;
   logic [SCORE_W-1:0]   req_score_a = '0;
   logic [SCORE_W-1:0]   req_score_b = '0;
   logic [SCORE_W-1:0]   req_score_c = '0;

   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   logic [STAT_W-1:0]    rsp_status;
   logic [KEY_W-1:0]     rsp_found_key;
   logic [SCORE_W-1:0]   rsp_found_a;
   logic [SCORE_W-1:0]   rsp_found_b;
   logic [SCORE_W-1:0]   rsp_found_c;
   logic [COUNT_W-1:0]   rsp_count;

   // Travels with the item on the request side: when set, the result is the
   // one typed into the directed table instead of the scoreboard's.
   bit          typed_row  = 1'b0;
   outcome_type typed_want;

   // scoreboard copy of the table
   rec_type     held_recs [DEPTH];
   int unsigned held_fill;

   outcome_type pending_outcomes [$];
   step_type    plan [$];
   logic [KEY_W-1:0] key_pool [16];

   int errors    = 0;
   int rsp_seen  = 0;
   int accepted  = 0;
   int cycles    = 0;
   int peak_fill = 0;
   int n_cmd  [4];
   int n_stat [4];
   bit held_off = 1'b0;

   record_table_search_delete_top i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_key       (req_key),
      .req_score_a   (req_score_a),
      .req_score_b   (req_score_b),
      .req_score_c   (req_score_c),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_found_key (rsp_found_key),
      .rsp_found_a   (rsp_found_a),
      .rsp_found_b   (rsp_found_b),
      .rsp_found_c   (rsp_found_c),
      .rsp_count     (rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, pending_outcomes.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Scoreboard model
   // ------------------------------------------------------------------------

   // A key is a C string: everything after the first NUL byte is dropped.
   function automatic logic [KEY_W-1:0] strip_after_nul(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] r;
      bit               ended;
      r     = '0;
      ended = 1'b0;
      for (int i = 3; i >= 0; i--) begin
         if (k[8*i +: 8] == 8'h00)
            ended = 1'b1;
         if (!ended)
            r[8*i +: 8] = k[8*i +: 8];
      end
      return r;
   endfunction

   // Only A..Z fold; every other byte compares as is.
   function automatic logic [KEY_W-1:0] lower_ascii(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] r;
      r = k;
      for (int i = 0; i < 4; i++)
         if (k[8*i +: 8] >= 8'h41 && k[8*i +: 8] <= 8'h5A)
            r[8*i +: 8] = k[8*i +: 8] + 8'h20;
      return r;
   endfunction

   // Runs one command on the scoreboard table and returns its result.
   function automatic outcome_type apply_command(input logic [CMD_W-1:0] cmd,
                                                 input logic [KEY_W-1:0] raw,
                                                 input logic [SCORE_W-1:0] sa,
                                                 input logic [SCORE_W-1:0] sb,
                                                 input logic [SCORE_W-1:0] sc);
      outcome_type      o;
      logic [KEY_W-1:0] k;
      int               hit;
      o.st  = ST_MISS;
      o.key = '0;
      o.a   = '0;
      o.b   = '0;
      o.c   = '0;
      k     = strip_after_nul(raw);
      hit   = -1;
      if (cmd == CMD_UNUSED) begin
         o.st = ST_MISS;
      end else if (k == '0) begin
         o.st = ST_EMPTY;
      end else if (cmd == CMD_INSERT) begin
         if (held_fill >= DEPTH) begin
            o.st = ST_FULL;
         end else begin
            held_recs[held_fill] = '{key: k, a: sa, b: sb, c: sc};
            held_fill++;
            o.st = ST_OK;
         end
      end else begin
         for (int i = 0; i < held_fill; i++)
            if (hit < 0 && lower_ascii(held_recs[i].key) == lower_ascii(k))
               hit = i;
         if (hit >= 0) begin
            o.st  = ST_OK;
            o.key = held_recs[hit].key;
            o.a   = held_recs[hit].a;
            o.b   = held_recs[hit].b;
            o.c   = held_recs[hit].c;
            if (cmd == CMD_DELETE) begin
               // close the gap, order kept
               for (int j = hit; j + 1 < held_fill; j++)
                  held_recs[j] = held_recs[j + 1];
               held_fill--;
            end
         end
      end
      o.cnt = COUNT_W'(held_fill);
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic flag_mismatch(input string what, input logic [KEY_W-1:0] got,
                                input logic [KEY_W-1:0] want);
      errors++;
      if (errors <= 40)
         $display("mismatch on result %0d: %s got %h expected %h",
                  rsp_seen, what, got, want);
   endtask

   // Results are checked before the new request is predicted: a result
   // never belongs to the item accepted on the same edge.
   always @(posedge clock) begin
      outcome_type want;
      outcome_type pred;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               flag_mismatch("unexpected result, status", KEY_W'(rsp_status), '0);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_status !== want.st)
                  flag_mismatch("status", KEY_W'(rsp_status), KEY_W'(want.st));
               if (rsp_found_key !== want.key)
                  flag_mismatch("found_key", rsp_found_key, want.key);
               if (rsp_found_a !== want.a)
                  flag_mismatch("found_a", KEY_W'(rsp_found_a), KEY_W'(want.a));
               if (rsp_found_b !== want.b)
                  flag_mismatch("found_b", KEY_W'(rsp_found_b), KEY_W'(want.b));
               if (rsp_found_c !== want.c)
                  flag_mismatch("found_c", KEY_W'(rsp_found_c), KEY_W'(want.c));
               if (rsp_count !== want.cnt)
                  flag_mismatch("count", KEY_W'(rsp_count), KEY_W'(want.cnt));
            end
            rsp_seen++;
         end
         if (req_valid && !req_stall) begin
            pred = apply_command(req_cmd, req_key, req_score_a, req_score_b, req_score_c);
            n_cmd[req_cmd]++;
            n_stat[pred.st]++;
            if (held_fill > peak_fill)
               peak_fill = held_fill;
            pending_outcomes.push_back(typed_row ? typed_want : pred);
            accepted++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver pacing: stretches of free flow, light and heavy stalling and
   // toggling, plus one long hold-off that backs the block up into its input.
   // ------------------------------------------------------------------------
   initial begin : rsp_pacing
      int mode;
      int span;
      forever begin
         if (!held_off && rsp_seen >= 700) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (600) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 150);
            for (int k = 0; k < span; k++) begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 99) < 25);
                  2: rsp_stall <= ($urandom_range(0, 99) < 60);
                  default: rsp_stall <= k[0];
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   function automatic void row_p(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                 input logic [SCORE_W-1:0] a, input logic [SCORE_W-1:0] b,
                                 input logic [SCORE_W-1:0] c);
      step_type s;
      s.cmd   = cmd;
      s.key   = key;
      s.a     = a;
      s.b     = b;
      s.c     = c;
      s.typed = 1'b0;
      s.want  = '{ST_MISS, '0, '0, '0, '0, '0};
      plan.push_back(s);
   endfunction

   function automatic void row_t(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                 input logic [SCORE_W-1:0] a, input logic [SCORE_W-1:0] b,
                                 input logic [SCORE_W-1:0] c, input status_type st,
                                 input logic [KEY_W-1:0] fkey, input logic [SCORE_W-1:0] fa,
                                 input logic [SCORE_W-1:0] fb, input logic [SCORE_W-1:0] fc,
                                 input logic [COUNT_W-1:0] cnt);
      step_type s;
      s.cmd   = cmd;
      s.key   = key;
      s.a     = a;
      s.b     = b;
      s.c     = c;
      s.typed = 1'b1;
      s.want  = '{st, fkey, fa, fb, fc, cnt};
      plan.push_back(s);
   endfunction

   // Random case per letter; bytes after a NUL get junk half the time.
   function automatic logic [KEY_W-1:0] vary_case(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] r;
      logic [7:0]       byt;
      bit               ended;
      r     = k;
      ended = 1'b0;
      for (int i = 3; i >= 0; i--) begin
         byt = k[8*i +: 8];
         if (ended) begin
            if ($urandom_range(0, 1))
               r[8*i +: 8] = 8'($urandom());
         end else if (byt == 8'h00) begin
            ended = 1'b1;
         end else if (((byt >= 8'h41 && byt <= 8'h5A) || (byt >= 8'h61 && byt <= 8'h7A))
                      && $urandom_range(0, 1)) begin
            r[8*i +: 8] = byt ^ 8'h20;
         end
      end
      return r;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)
         return $urandom();
      else if (r < 11)
         return {8'h00, 24'($urandom())};  // empty key with junk behind it
      else
         return vary_case(key_pool[$urandom_range(0, 15)]);
   endfunction

   function automatic logic [SCORE_W-1:0] pick_score();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3)
         return '0;
      else if (r < 6)
         return SCORE_W'(1000);
      else if (r < 14)
         return SCORE_W'($urandom_range(1001, 1023));  // above the legal range
      else
         return SCORE_W'($urandom_range(0, 1000));
   endfunction

   // Sender side: one item held until accepted. Valid stays up between
   // back-to-back items.
   int burst_left = 0;

   task automatic offer(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                        input logic [SCORE_W-1:0] a, input logic [SCORE_W-1:0] b,
                        input logic [SCORE_W-1:0] c, input bit typed,
                        input outcome_type want);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_key     <= key;
      req_score_a <= a;
      req_score_b <= b;
      req_score_c <= c;
      typed_row   <= typed;
      typed_want  <= want;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   initial begin : stimulus
      int               phase;
      int               phase_left;
      int               r;
      logic [CMD_W-1:0] cmd;
      outcome_type      none;

      phase      = 2;
      phase_left = 0;
      none       = '{ST_MISS, '0, '0, '0, '0, '0};

      // letters, short keys, bytes just outside A..Z and a..z, high bytes
      key_pool = '{32'h61626364, 32'h41424345, 32'h7A7A0000, 32'h71000000,
                   32'h4D783921, 32'h40626300, 32'h60626300, 32'h5B5D0000,
                   32'h7B7D0000, 32'hC1C2C3C4, 32'hE1E2E3E4, 32'h4B657931,
                   32'h6B657932, 32'h615A5F7A, 32'h7F01FF80, 32'h5A5A5A5A};

      // Directed table. Typed rows are plain to read off; the rest go
      // through the scoreboard.
      row_t(CMD_SEARCH, 32'h61626364, 0, 0, 0, ST_MISS, '0, 0, 0, 0, 0);     // empty table
      row_t(CMD_DELETE, 32'h61626364, 0, 0, 0, ST_MISS, '0, 0, 0, 0, 0);
      row_t(CMD_INSERT, 32'h00000000, 5, 5, 5, ST_EMPTY, '0, 0, 0, 0, 0);
      row_t(CMD_INSERT, 32'h00FFFFFF, 5, 5, 5, ST_EMPTY, '0, 0, 0, 0, 0);    // junk after NUL
      row_t(CMD_UNUSED, 32'h61626364, 9, 9, 9, ST_MISS, '0, 0, 0, 0, 0);
      row_t(CMD_INSERT, 32'h41424344, 0, 0, 0, ST_OK, '0, 0, 0, 0, 1);       // "ABCD"
      row_t(CMD_INSERT, 32'h7778797A, 1000, 1000, 1000, ST_OK, '0, 0, 0, 0, 2);
      row_t(CMD_INSERT, 32'hFFFFFFFF, 1023, 1023, 1023, ST_OK, '0, 0, 0, 0, 3);
      row_t(CMD_INSERT, 32'h61620058, 1, 2, 3, ST_OK, '0, 0, 0, 0, 4);       // stored as "ab"
      row_t(CMD_SEARCH, 32'h61626364, 7, 7, 7, ST_OK, 32'h41424344, 0, 0, 0, 4);
      row_p(CMD_SEARCH, 32'h41420077, 0, 0, 0);     // "AB" finds "ab"
      row_p(CMD_SEARCH, 32'h40626364, 0, 0, 0);     // '@' does not fold to 'a'
      row_p(CMD_INSERT, 32'h405B5E60, 5, 6, 7);
      row_p(CMD_SEARCH, 32'h607B7E40, 0, 0, 0);     // neighbors of the letter ranges
      row_p(CMD_SEARCH, 32'h405B5E60, 0, 0, 0);
      row_p(CMD_SEARCH, 32'hFFFFFFFF, 0, 0, 0);
      row_t(CMD_UNUSED, 32'hFFFFFFFF, 1023, 1023, 1023, ST_MISS, '0, 0, 0, 0, 5);
      row_p(CMD_DELETE, 32'h41624364, 0, 0, 0);     // delete at the head
      row_p(CMD_SEARCH, 32'h61626364, 0, 0, 0);
      row_p(CMD_DELETE, 32'hFFFFFFFF, 0, 0, 0);     // delete in the middle
      row_p(CMD_INSERT, 32'h5758595A, 11, 22, 33);  // duplicate key, other case
      row_p(CMD_DELETE, 32'h7758795A, 0, 0, 0);     // removes the first of the two
      row_p(CMD_SEARCH, 32'h7778797A, 0, 0, 0);
      row_p(CMD_SEARCH, 32'h00414243, 0, 0, 0);
      row_p(CMD_DELETE, 32'h00000000, 0, 0, 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         offer(plan[i].cmd, plan[i].key, plan[i].a, plan[i].b, plan[i].c,
               plan[i].typed, plan[i].want);

      // Random part in phases: filling (runs into full), mixed, draining.
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (phase_left == 0) begin
            phase      = (phase + 1) % 3;
            phase_left = $urandom_range(200, 320);
         end
         phase_left--;
         r = $urandom_range(0, 99);
         if (r < 3)
            cmd = CMD_UNUSED;
         else if (phase == 0)
            cmd = (r < 78) ? CMD_INSERT : (r < 90) ? CMD_SEARCH : CMD_DELETE;
         else if (phase == 1)
            cmd = (r < 38) ? CMD_INSERT : (r < 72) ? CMD_SEARCH : CMD_DELETE;
         else
            cmd = (r < 13) ? CMD_INSERT : (r < 33) ? CMD_SEARCH : CMD_DELETE;
         offer(cmd, pick_key(), pick_score(), pick_score(), pick_score(), 1'b0, none);
      end
      req_valid <= 1'b0;

      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d items (insert %0d, search %0d, delete %0d, unused %0d), %0d results",
               accepted, n_cmd[CMD_INSERT], n_cmd[CMD_SEARCH], n_cmd[CMD_DELETE],
               n_cmd[CMD_UNUSED], rsp_seen);
      $display("outcomes: done/found %0d, not found %0d, full %0d, empty key %0d;",
               n_stat[ST_OK], n_stat[ST_MISS], n_stat[ST_FULL], n_stat[ST_EMPTY],
               " peak fill %0d/%0d", peak_fill, DEPTH);
      if (errors == 0 && pending_outcomes.size() == 0 && rsp_seen == accepted) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d results outstanding", errors, pending_outcomes.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: record_table_search_delete_top.f
+incdir+sv
sv/rts_pkg.sv
sv/rts_mem.sv
sv/rts_ctrl.sv
sv/record_table_search_delete_top.sv
tb/record_table_search_delete_top_tb.sv
